>>> rtl/sc2tb_pkg.sv
`default_nettype none

package sc2tb_pkg;

  localparam int WORD_W = 16;
  localparam int BYTE_W = 8;

  // translate_mode codes
  localparam logic [1:0] MODE_ASCII = 2'd0;
  localparam logic [1:0] MODE_ESC   = 2'd1;
  localparam logic [1:0] MODE_WORD  = 2'd2;

  localparam logic [BYTE_W-1:0] CH_ESC    = 8'h1B;
  localparam logic [BYTE_W-1:0] CH_LBRACK = 8'h5B;
  localparam logic [BYTE_W-1:0] CH_TILDE  = 8'h7E;

  typedef enum logic {
    KIND_WORD,  // one word, last
    KIND_ESC    // escape run: ESC [ ch (~)
  } kind_t;

  // One queued job for the back end
  typedef struct packed {
    kind_t             kind;
    logic              long_run;  // escape run carries a trailing tilde
    logic [WORD_W-1:0] word;      // full word, or the escape char in the low byte
  } desc_t;

endpackage

`default_nettype wire

>>> rtl/sc2tb_front.sv
`default_nettype none

module sc2tb_front (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         cfg_we,
  input  wire  [1:0]                  cfg_wdata,
  input  wire                         in_tvalid,
  output logic                        in_tready,
  input  wire  [sc2tb_pkg::WORD_W-1:0] in_tdata,
  input  wire                         q_ready,
  output logic                        q_push,
  output sc2tb_pkg::desc_t            q_desc
);
  import sc2tb_pkg::*;

  typedef struct packed {
    logic              hit;
    logic              long_run;
    logic [BYTE_W-1:0] ch;
  } esc_entry_t;

  function automatic esc_entry_t esc_lookup(input logic [BYTE_W-1:0] sc);
    esc_entry_t e;
    e.hit      = 1'b1;
    e.long_run = 1'b0;
    e.ch       = 8'h00;
    case (sc) inside
      [8'h3B:8'h44]: e.ch = 8'h61 + (sc - 8'h3B);  // F1..F10 -> a..j
      8'h85:         e.ch = 8'h6B;                 // k
      8'h86:         e.ch = 8'h6C;                 // l
      8'h47:         e.ch = 8'h48;                 // H
      8'h48:         e.ch = 8'h41;                 // A
      8'h4B:         e.ch = 8'h44;                 // D
      8'h4D:         e.ch = 8'h43;                 // C
      8'h4F:         e.ch = 8'h46;                 // F
      8'h50:         e.ch = 8'h42;                 // B
      8'h49: begin
        e.ch = 8'h35;
        e.long_run = 1'b1;
      end
      8'h51: begin
        e.ch = 8'h36;
        e.long_run = 1'b1;
      end
      8'h53: begin
        e.ch = 8'h33;
        e.long_run = 1'b1;
      end
      default: e.hit = 1'b0;
    endcase
    return e;
  endfunction

  logic [1:0]        mode_r;
  logic [BYTE_W-1:0] lo, hi;
  esc_entry_t        ent;
  logic              emits;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_ASCII;
    end else if (cfg_we) begin
      mode_r <= cfg_wdata;
    end
  end

  assign lo  = in_tdata[BYTE_W-1:0];
  assign hi  = in_tdata[WORD_W-1:BYTE_W];
  assign ent = esc_lookup(hi);

  always_comb begin
    emits           = 1'b0;
    q_desc.kind     = KIND_WORD;
    q_desc.long_run = ent.long_run;
    q_desc.word     = in_tdata;
    if (in_tdata == '0) begin
      emits = 1'b0;
    end else if (mode_r == MODE_WORD) begin
      emits = 1'b1;
    end else if (lo != '0) begin
      emits       = 1'b1;
      q_desc.word = {{(WORD_W-BYTE_W){1'b0}}, lo};
    end else if (mode_r == MODE_ESC && ent.hit) begin
      emits       = 1'b1;
      q_desc.kind = KIND_ESC;
      q_desc.word = {{(WORD_W-BYTE_W){1'b0}}, ent.ch};
    end
  end

  // items that produce nothing are consumed here
  assign in_tready = q_ready;
  assign q_push    = in_tvalid && q_ready && emits;

endmodule

`default_nettype wire

>>> rtl/sc2tb_fifo.sv
`default_nettype none

module sc2tb_fifo #(
  parameter int DEPTH = 2
) (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               push,
  input  sc2tb_pkg::desc_t  push_desc,
  output logic              ready,
  input  wire               pop,
  output logic              valid,
  output sc2tb_pkg::desc_t  pop_desc
);
  import sc2tb_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  desc_t         mem [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign ready    = (count_r != CW'(DEPTH));
  assign valid    = (count_r != '0);
  assign pop_desc = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (pop)  rd_ptr_r <= ptr_inc(rd_ptr_r);
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/sc2tb_back.sv
`default_nettype none

module sc2tb_back (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          q_valid,
  input  sc2tb_pkg::desc_t             q_desc,
  output logic                         q_pop,
  output logic                         out_tvalid,
  input  wire                          out_tready,
  output logic [sc2tb_pkg::WORD_W-1:0] out_tdata,
  output logic                         out_tlast
);
  import sc2tb_pkg::*;

  logic              act_r, act_nxt;
  desc_t             desc_r;
  logic [1:0]        step_r;
  logic              out_valid_r;
  logic [WORD_W-1:0] out_data_r, out_data_nxt;
  logic              out_last_r, out_last_nxt;

  desc_t      cur;
  logic [1:0] cur_step;
  logic       have, load;

  assign have     = act_r || q_valid;
  assign cur      = act_r ? desc_r : q_desc;
  assign cur_step = act_r ? step_r : 2'd0;
  assign load     = have && (!out_valid_r || out_tready);
  assign q_pop    = load && !act_r;

  always_comb begin
    out_data_nxt = cur.word;
    out_last_nxt = 1'b1;
    if (cur.kind == KIND_ESC) begin
      case (cur_step)
        2'd0:    out_data_nxt = {{(WORD_W-BYTE_W){1'b0}}, CH_ESC};
        2'd1:    out_data_nxt = {{(WORD_W-BYTE_W){1'b0}}, CH_LBRACK};
        2'd2:    out_data_nxt = cur.word;
        default: out_data_nxt = {{(WORD_W-BYTE_W){1'b0}}, CH_TILDE};
      endcase
      out_last_nxt = cur.long_run ? (cur_step == 2'd3) : (cur_step == 2'd2);
    end
    act_nxt = !out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        act_r       <= act_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      desc_r     <= cur;
      step_r     <= cur_step + 2'd1;
      out_data_r <= out_data_nxt;
      out_last_r <= out_last_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

>>> rtl/scancode_to_terminal_bytes_core.sv
`default_nettype none

// Channel  | Dir | tdata (low bit up)              | tlast
// ---------+-----+---------------------------------+---------------------------
// in_      | in  | [15:0] scan_code                | -
// out_     | out | [15:0] out_word                 | last word of an item's run
// cfg_     | in  | [1:0]  translate_mode (on cfg_we) | -
//
// One word leaves per cycle from the output register while out_tready is high;
// the front end is combinational; the back end emits 1, 3 or 4 words per item.
// Items that emit nothing are consumed by the front end and queue no job.
// The front end stalls only when the job queue (FIFO_DEPTH entries) is full.
// Reset is synchronous, active low; translate_mode resets to 0.
module scancode_to_terminal_bytes_core #(
  parameter int FIFO_DEPTH = 2
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          cfg_we,
  input  wire  [1:0]                   cfg_wdata,    // [1:0] translate_mode
  input  wire                          in_tvalid,
  output logic                         in_tready,
  input  wire  [sc2tb_pkg::WORD_W-1:0] in_tdata,     // [15:0] scan_code
  output logic                         out_tvalid,
  input  wire                          out_tready,
  output logic [sc2tb_pkg::WORD_W-1:0] out_tdata,    // [15:0] out_word
  output logic                         out_tlast
);
  import sc2tb_pkg::*;

  logic  q_push, q_ready, q_pop, q_valid;
  desc_t q_in, q_out;

  sc2tb_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_ready   (q_ready),
    .q_push    (q_push),
    .q_desc    (q_in)
  );

  sc2tb_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_desc (q_in),
    .ready     (q_ready),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_desc  (q_out)
  );

  sc2tb_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_desc     (q_out),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

`ifndef ASSERT_OFF
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> q_ready) else $error("push into full job queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid) else $error("pop from empty job queue");

  a_zero_item_dropped: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tdata == '0) |-> !q_push)
    else $error("zero word queued a job");

  a_mid_run_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tlast) |-> out_tdata[WORD_W-1:BYTE_W] == '0)
    else $error("non-final word is not a byte");
`endif

endmodule

`default_nettype wire

>>> bench/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import sc2tb_pkg::*;

  localparam logic [1:0] MODE_SPARE = 2'd3;  // unused code, decodes as ascii-only
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 12;
  localparam int MAX_REPORTS = 10;

  // scan codes that own an escape run
  localparam logic [BYTE_W-1:0] KEY_F1    = 8'h3B;
  localparam logic [BYTE_W-1:0] KEY_F10   = 8'h44;
  localparam logic [BYTE_W-1:0] KEY_HOME  = 8'h47;
  localparam logic [BYTE_W-1:0] KEY_UP    = 8'h48;
  localparam logic [BYTE_W-1:0] KEY_PGUP  = 8'h49;
  localparam logic [BYTE_W-1:0] KEY_LEFT  = 8'h4B;
  localparam logic [BYTE_W-1:0] KEY_RIGHT = 8'h4D;
  localparam logic [BYTE_W-1:0] KEY_END   = 8'h4F;
  localparam logic [BYTE_W-1:0] KEY_DOWN  = 8'h50;
  localparam logic [BYTE_W-1:0] KEY_PGDN  = 8'h51;
  localparam logic [BYTE_W-1:0] KEY_DEL   = 8'h53;
  localparam logic [BYTE_W-1:0] KEY_F11   = 8'h85;
  localparam logic [BYTE_W-1:0] KEY_F12   = 8'h86;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              last;
  } term_word_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_we = 1'b0;
  logic [1:0]        cfg_wdata = 2'd0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [WORD_W-1:0] in_tdata = '0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [WORD_W-1:0] out_tdata;
  logic              out_tlast;

  logic [1:0]   tb_mode = MODE_ASCII;
  term_word_t   pending_words[$];
  int           send_idle_pct = 0;
  int           recv_stall_pct = 0;
  int           hold_request = 0;
  int           items_sent = 0;
  int           words_checked = 0;
  int           mismatches = 0;
  int           quiet_cycles = 0;

  scancode_to_terminal_bytes_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic logic [BYTE_W-1:0] esc_key(input int idx);
    if (idx < 10) return KEY_F1 + BYTE_W'(idx);
    case (idx)
      10: return KEY_F11;
      11: return KEY_F12;
      12: return KEY_HOME;
      13: return KEY_UP;
      14: return KEY_PGUP;
      15: return KEY_LEFT;
      16: return KEY_RIGHT;
      17: return KEY_END;
      18: return KEY_DOWN;
      19: return KEY_PGDN;
      default: return KEY_DEL;
    endcase
  endfunction

  function automatic logic [WORD_W-1:0] random_key_code();
    int pick;
    pick = $urandom_range(99);
    if (pick < 40) return {esc_key($urandom_range(20)), 8'h00};
    else if (pick < 50) return {BYTE_W'($urandom), 8'h00};
    else if (pick < 58) return '0;
    else if (pick < 68) return {8'h00, BYTE_W'($urandom)};
    else return WORD_W'($urandom);
  endfunction

  task automatic push_word(input logic [WORD_W-1:0] word, input logic last);
    term_word_t w;
    w.word = word;
    w.last = last;
    pending_words.push_back(w);
  endtask

  // Expected queue words for one key code under the current mode.
  task automatic predict_terminal_words(input logic [WORD_W-1:0] code);
    logic [BYTE_W-1:0] lo, hi, ch;
    logic              tilde, hit;
    lo = code[BYTE_W-1:0];
    hi = code[WORD_W-1:BYTE_W];
    ch = '0;
    tilde = 1'b0;
    hit = 1'b1;
    if (code == '0) return;
    if (tb_mode == MODE_WORD) begin
      push_word(code, 1'b1);
      return;
    end
    if (lo != '0) begin
      push_word(WORD_W'(lo), 1'b1);
      return;
    end
    if (tb_mode != MODE_ESC) return;
    if (hi >= KEY_F1 && hi <= KEY_F10) begin
      ch = "a" + (hi - KEY_F1);
    end else begin
      case (hi)
        KEY_F11:   ch = "k";
        KEY_F12:   ch = "l";
        KEY_HOME:  ch = "H";
        KEY_UP:    ch = "A";
        KEY_LEFT:  ch = "D";
        KEY_RIGHT: ch = "C";
        KEY_END:   ch = "F";
        KEY_DOWN:  ch = "B";
        KEY_PGUP:  begin ch = "5"; tilde = 1'b1; end
        KEY_PGDN:  begin ch = "6"; tilde = 1'b1; end
        KEY_DEL:   begin ch = "3"; tilde = 1'b1; end
        default:   hit = 1'b0;
      endcase
    end
    if (!hit) return;
    push_word(WORD_W'(CH_ESC), 1'b0);
    push_word(WORD_W'(CH_LBRACK), 1'b0);
    push_word(WORD_W'(ch), !tilde);
    if (tilde) push_word(WORD_W'(CH_TILDE), 1'b1);
  endtask

  // Called and returns at a falling edge.
  task automatic send_code(input logic [WORD_W-1:0] code);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      in_tdata = WORD_W'($urandom);
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata = code;
    do @(posedge clk); while (!in_tready);
    predict_terminal_words(code);
    items_sent++;
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  task automatic drain();
    in_tvalid = 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    // settle after the last expected word has been checked
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_mode(input logic [1:0] mode);
    drain();
    cfg_we = 1'b1;
    cfg_wdata = mode;
    @(negedge clk);
    cfg_we = 1'b0;
    tb_mode = mode;
  endtask

  task automatic set_traffic(input int send_pct, input int recv_pct);
    @(posedge clk);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    @(negedge clk);
  endtask

  task automatic test_directed_keys();
    set_traffic(0, 0);
    // reset value of the mode is ascii-only
    send_code(16'h0000);
    send_code(16'h1E61);
    send_code({KEY_F1, 8'h00});
    send_code(16'hFFFF);
    write_mode(MODE_ESC);
    for (int i = 0; i <= 20; i++) send_code({esc_key(i), 8'h00});
    send_code(16'h4500);  // just past F10, no entry
    send_code(16'hFF00);
    send_code(16'h1C0D);
    send_code(16'h0000);
    write_mode(MODE_WORD);
    send_code(16'h0000);
    send_code(16'hFF00);
    send_code(16'h0001);
    write_mode(MODE_SPARE);
    send_code(16'h1E61);
    send_code({KEY_UP, 8'h00});
  endtask

  task automatic test_random_keys();
    logic [1:0] mode;
    for (int seg = 0; seg < 8; seg++) begin
      if (seg % 2 == 0) begin
        mode = MODE_ESC;
      end else begin
        case (seg / 2)
          0: mode = MODE_ASCII;
          1: mode = MODE_WORD;
          2: mode = MODE_SPARE;
          default: mode = MODE_ASCII;
        endcase
      end
      write_mode(mode);
      case (seg / 2)
        0: set_traffic(0, 0);
        1: set_traffic(84, 0);
        2: set_traffic(0, 84);
        default: set_traffic(14, 14);
      endcase
      repeat (17) send_code(random_key_code());
    end
  endtask

  task automatic test_backpressure();
    write_mode(MODE_ESC);
    set_traffic(0, 0);
    @(posedge clk);
    hold_request = 120;
    @(negedge clk);
    for (int i = 9; i <= 20; i++) send_code({esc_key(i), 8'h00});
  endtask

  // receiver side: random stalls plus a long hold-off on request
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready = 1'b0;
      end else begin
        out_tready = ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin : check_words
    term_word_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_words.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected word %h last %b", out_tdata, out_tlast);
      end else begin
        want = pending_words.pop_front();
        words_checked++;
        if (out_tdata !== want.word || out_tlast !== want.last) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("word %0d: expected %h last %b, got %h last %b", words_checked,
                     want.word, want.last, out_tdata, out_tlast);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_directed_keys();
    test_random_keys();
    test_backpressure();
    in_tvalid = 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Sent %0d key codes in all four mode settings, with idle, stall and hold-off",
             items_sent);
    $display("Checked %0d terminal words, %0d mismatches", words_checked, mismatches);
    if (mismatches == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
